### design/fpc_pkg.sv
// fpc_pkg: shared codes, constants and control/status types of the frustum cull block
`timescale 1ns / 1ps
package fpc_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_BOX    = 2'd1;
   localparam logic [1:0] CMD_SPHERE = 2'd2;
   // unused kind, answered as visible with no state change
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // multiplier operand selection
   localparam logic [1:0] MK_SQ   = 2'd0;
   localparam logic [1:0] MK_DIST = 2'd1;
   localparam logic [1:0] MK_SPRD = 2'd2;

   localparam int PLANES      = 6;
   localparam int NRM_FRAC    = 30;
   localparam int OFF_FRAC    = 16;
   localparam int SHORT_SHIFT = 14;
   // squared length at or below this counts as a degenerate plane
   localparam int LEN_MIN_SQ  = 42;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       capture;
      logic       mat_wr;
      logic       a_en;
      logic       mul_en;
      logic [1:0] mul_kind;
      logic       acc_clr;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_wr;
      logic       short_wr;
      logic       res_init;
      logic       res_cull;
      logic       res_mark;
      logic       out_load;
      logic [2:0] plane;
      logic [2:0] step;
   } ctl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       plane_on;
      logic       s_small;
      logic       box_cull;
      logic       box_straddle;
      logic       sph_cull;
   } sts_type;

endpackage

### design/fpc_dpath.sv
// fpc_dpath: plane store, shared multiplier, accumulators, square root and divider
`timescale 1ns / 1ps
module fpc_dpath #(
   parameter int DATA_WIDTH = 32,
   localparam int REQ_TW = ((7 * DATA_WIDTH + 5 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fpc_pkg::ctl_type      ctl,
   output fpc_pkg::sts_type      sts,
   input  logic [REQ_TW-1:0]     req_tdata,
   input  logic [1:0]            req_tuser,
   output logic [7:0]            rsp_tdata
);

   localparam int W  = DATA_WIDTH;
   localparam int MW = W + 1;
   localparam int AW = 2 * MW;
   localparam int NW = W + fpc_pkg::NRM_FRAC;
   localparam int SW = NW + 1;
   localparam int OV = 2;
   localparam int OE = OV + 4 * W;
   localparam int OM = OE + 3 * (W - 1);
   localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
   localparam logic signed [AW-1:0] BIAS =
      {{(AW-fpc_pkg::NRM_FRAC){1'b0}}, {fpc_pkg::NRM_FRAC{1'b1}}};
   localparam logic signed [AW-1:0] LMIN = AW'(fpc_pkg::LEN_MIN_SQ);

   function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
      if (x > SAT_HI) begin
         return SAT_HI[W-1:0];
      end else if (x < SAT_LO) begin
         return SAT_LO[W-1:0];
      end
      return x[W-1:0];
   endfunction

   // captured item
   logic [1:0]            cmd_ff;
   logic [1:0]            grp_ff;
   logic signed [W-1:0]   v_ff [4];
   logic [W-2:0]          e_ff [3];
   logic [5:0]            msk_ff;

   // matrix and plane store
   logic signed [W-1:0]   mat_ff [16];
   logic signed [W-1:0]   nrm_ff [18];
   logic signed [W-1:0]   off_ff [6];
   logic signed [W-1:0]   a_ff [4];

   // multiplier and accumulators
   logic signed [AW-1:0]  prod_ff;
   logic [1:0]            kind_ff;
   logic                  pend_ff;
   logic signed [AW-1:0]  accd_ff;
   logic signed [AW-1:0]  accs_ff;

   // square root and divider
   logic [2*W-1:0]        sqsrc_ff;
   logic [W-1:0]          res_ff;
   logic [W+1:0]          srem_ff;
   logic [NW-1:0]         dq_ff;
   logic [W-1:0]          drem_ff;
   logic                  dneg_ff;

   // result and output registers
   logic                  vis_ff;
   logic [5:0]            cm_ff;
   logic [7:0]            out_ff;

   logic [1:0]            ax;
   logic [1:0]            kcol;
   logic                  minus;
   logic signed [W-1:0]   mx;
   logic signed [W-1:0]   my;
   logic signed [W:0]     asum;
   logic [4:0]            nbase;
   logic [4:0]            nidx;
   logic signed [W-1:0]   nsel;
   logic signed [MW-1:0]  nsx;
   logic signed [MW-1:0]  nabs;
   logic signed [MW-1:0]  opa;
   logic signed [MW-1:0]  opb;
   logic signed [AW-1:0]  pbias;
   logic signed [AW-1:0]  ptr;
   logic signed [AW-1:0]  offx;
   logic [W+3:0]          rsh;
   logic [W+3:0]          trial;
   logic [W+3:0]          sdiff;
   logic signed [W-1:0]   am;
   logic [W-1:0]          mag;
   logic [W:0]            tsh;
   logic [W:0]            den;
   logic [W:0]            tdiff;
   logic signed [SW-1:0]  qs;
   logic signed [SW-1:0]  qv;
   logic signed [W-1:0]   qsat;
   logic [2:0]            pl;

   assign ax    = ctl.step[1:0];
   assign kcol  = ctl.plane[2:1];
   assign pl    = ctl.plane;
   assign minus = (pl == 3'd0) || (pl == 3'd3) || (pl == 3'd4);

   // plane coefficient from the matrix: last column against column k
   assign mx   = mat_ff[{ax, 2'b11}];
   assign my   = mat_ff[{ax, kcol}];
   assign asum = minus ? ((W+1)'(mx) - (W+1)'(my)) : ((W+1)'(mx) + (W+1)'(my));

   // normal selection for the shared multiplier
   assign nbase = 5'(pl) * 5'd3;
   assign nidx  = nbase + 5'(ax);
   assign nsel  = (nidx < 5'd18) ? nrm_ff[nidx] : '0;
   assign nsx   = MW'(nsel);
   assign nabs  = nsel[W-1] ? -nsx : nsx;
   assign offx  = (pl < 3'd6) ? AW'(off_ff[pl]) : '0;

   always_comb begin
      case (ctl.mul_kind)
         fpc_pkg::MK_SQ: begin
            opa = MW'(a_ff[ax]);
            opb = MW'(a_ff[ax]);
         end
         fpc_pkg::MK_DIST: begin
            opa = nsx;
            opb = MW'(v_ff[ax]);
         end
         fpc_pkg::MK_SPRD: begin
            opa = nabs;
            opb = $signed({2'b00, e_ff[(ax < 2'd3) ? ax : 2'd0]});
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // product scaled back from Q2.30, truncated toward zero
   assign pbias = prod_ff + (prod_ff[AW-1] ? BIAS : '0);
   assign ptr   = pbias >>> fpc_pkg::NRM_FRAC;

   // square root digit step
   assign rsh   = {srem_ff, sqsrc_ff[2*W-1 -: 2]};
   assign trial = {2'b00, res_ff, 2'b01};
   assign sdiff = rsh - trial;

   // divider setup and step
   assign am    = a_ff[ax];
   assign mag   = am[W-1] ? W'(-am) : W'(am);
   assign tsh   = {drem_ff, dq_ff[NW-1]};
   assign den   = {1'b0, res_ff};
   assign tdiff = tsh - den;
   assign qs    = $signed({1'b0, dq_ff});
   assign qv    = dneg_ff ? -qs : qs;
   assign qsat  = sat_w(qv);

   // status toward the controller
   assign sts.cmd          = cmd_ff;
   assign sts.plane_on     = (cmd_ff == fpc_pkg::CMD_SPHERE) || ((pl < 3'd6) && msk_ff[pl]);
   assign sts.s_small      = accd_ff <= LMIN;
   assign sts.box_cull     = (accd_ff + accs_ff) < 0;
   assign sts.box_straddle = (accd_ff - accs_ff) < 0;
   assign sts.sph_cull     = (accd_ff + AW'(v_ff[3])) <= 0;

   // item capture
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= req_tuser;
         grp_ff <= req_tdata[1:0];
         for (int i = 0; i < 4; i++) begin
            v_ff[i] <= req_tdata[OV + i*W +: W];
         end
         for (int i = 0; i < 3; i++) begin
            e_ff[i] <= req_tdata[OE + i*(W-1) +: (W-1)];
         end
         msk_ff <= req_tdata[OM +: 6];
      end
   end

   // matrix and plane store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= '0;
         end
         for (int i = 0; i < 18; i++) begin
            nrm_ff[i] <= '0;
         end
         for (int i = 0; i < 6; i++) begin
            off_ff[i] <= '0;
         end
      end else begin
         if (ctl.mat_wr) begin
            for (int i = 0; i < 4; i++) begin
               mat_ff[{grp_ff, 2'(i)}] <= v_ff[i];
            end
         end
         if (ctl.short_wr && (pl < 3'd6)) begin
            for (int i = 0; i < 3; i++) begin
               nrm_ff[nbase + 5'(i)] <= sat_w(SW'(a_ff[i]) <<< fpc_pkg::SHORT_SHIFT);
            end
            off_ff[pl] <= a_ff[3];
         end
         if (ctl.div_wr && (pl < 3'd6)) begin
            if (ax == 2'd3) begin
               off_ff[pl] <= qsat;
            end else begin
               nrm_ff[nidx] <= qsat;
            end
         end
      end
   end

   // plane coefficients
   always_ff @(posedge clock) begin
      if (ctl.a_en) begin
         a_ff[ax] <= sat_w(SW'(asum));
      end
   end

   // shared multiplier; the registered product is added in the cycle after
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctl.mul_en;
      end
      if (ctl.mul_en) begin
         prod_ff <= opa * opb;
         kind_ff <= ctl.mul_kind;
      end
   end

   // accumulators
   always_ff @(posedge clock) begin
      if (ctl.acc_clr) begin
         accd_ff <= (cmd_ff == fpc_pkg::CMD_LOAD) ? '0 : offx;
         accs_ff <= '0;
      end else if (pend_ff) begin
         case (kind_ff)
            fpc_pkg::MK_SQ:   accd_ff <= accd_ff + prod_ff;
            fpc_pkg::MK_DIST: accd_ff <= accd_ff + ptr;
            fpc_pkg::MK_SPRD: accs_ff <= accs_ff + (prod_ff >>> fpc_pkg::NRM_FRAC);
            default: ;
         endcase
      end
   end

   // bit-serial square root, two radicand bits a cycle
   always_ff @(posedge clock) begin
      if (ctl.sqrt_init) begin
         sqsrc_ff <= accd_ff[2*W-1:0];
         res_ff   <= '0;
         srem_ff  <= '0;
      end else if (ctl.sqrt_step) begin
         sqsrc_ff <= sqsrc_ff << 2;
         if (rsh >= trial) begin
            srem_ff <= sdiff[W+1:0];
            res_ff  <= {res_ff[W-2:0], 1'b1};
         end else begin
            srem_ff <= rsh[W+1:0];
            res_ff  <= {res_ff[W-2:0], 1'b0};
         end
      end
   end

   // restoring divider, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (ctl.div_init) begin
         dq_ff   <= (ax == 2'd3) ? (NW'(mag) << fpc_pkg::OFF_FRAC)
                                 : (NW'(mag) << fpc_pkg::NRM_FRAC);
         drem_ff <= '0;
         dneg_ff <= am[W-1];
      end else if (ctl.div_step) begin
         if (tsh >= den) begin
            drem_ff <= tdiff[W-1:0];
            dq_ff   <= {dq_ff[NW-2:0], 1'b1};
         end else begin
            drem_ff <= tsh[W-1:0];
            dq_ff   <= {dq_ff[NW-2:0], 1'b0};
         end
      end
   end

   // result flags and output register
   always_ff @(posedge clock) begin
      if (ctl.res_init) begin
         vis_ff <= 1'b1;
         cm_ff  <= '0;
      end else begin
         if (ctl.res_cull) begin
            vis_ff <= 1'b0;
         end
         if (ctl.res_mark && (pl < 3'd6)) begin
            cm_ff[pl] <= 1'b1;
         end
      end
      if (ctl.out_load) begin
         out_ff <= {1'b0, cm_ff, vis_ff};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

### design/fpc_ctrl.sv
// fpc_ctrl: sequencer for matrix loads, plane rebuild and box/sphere tests
`timescale 1ns / 1ps
module fpc_ctrl #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  fpc_pkg::sts_type      sts,
   output fpc_pkg::ctl_type      ctl
);

   localparam int NW = DATA_WIDTH + fpc_pkg::NRM_FRAC;
   localparam int CW = $clog2(NW);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEC  = 4'd1;
   localparam logic [3:0] S_BA   = 4'd2;
   localparam logic [3:0] S_BQ   = 4'd3;
   localparam logic [3:0] S_BW   = 4'd4;
   localparam logic [3:0] S_SQI  = 4'd5;
   localparam logic [3:0] S_SQS  = 4'd6;
   localparam logic [3:0] S_DVI  = 4'd7;
   localparam logic [3:0] S_DVS  = 4'd8;
   localparam logic [3:0] S_DVW  = 4'd9;
   localparam logic [3:0] S_TP   = 4'd10;
   localparam logic [3:0] S_TM   = 4'd11;
   localparam logic [3:0] S_TW   = 4'd12;
   localparam logic [3:0] S_TE   = 4'd13;
   localparam logic [3:0] S_DONE = 4'd14;

   localparam logic [2:0] LAST_PLANE = 3'(fpc_pkg::PLANES - 1);
   localparam logic [2:0] END_PLANE  = 3'(fpc_pkg::PLANES);

   logic [3:0]    state_ff, state_in;
   logic [2:0]    plane_ff, plane_in;
   logic [2:0]    step_ff, step_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rv_ff, rv_in;
   logic          is_sph;

   assign is_sph     = sts.cmd == fpc_pkg::CMD_SPHERE;
   assign rsp_tvalid = rv_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      plane_in   = plane_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      ctl        = '0;
      ctl.plane  = plane_ff;
      ctl.step   = step_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            ctl.res_init = 1'b1;
            plane_in     = '0;
            step_in      = '0;
            case (sts.cmd)
               fpc_pkg::CMD_LOAD: begin
                  ctl.mat_wr = 1'b1;
                  state_in   = S_BA;
               end
               fpc_pkg::CMD_BOX, fpc_pkg::CMD_SPHERE: state_in = S_TP;
               default: state_in = S_DONE;
            endcase
         end
         // coefficients of one plane, one per cycle
         S_BA: begin
            ctl.a_en = 1'b1;
            if (step_ff == 3'd3) begin
               ctl.acc_clr = 1'b1;
               step_in     = '0;
               state_in    = S_BQ;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         // squared length
         S_BQ: begin
            ctl.mul_en   = 1'b1;
            ctl.mul_kind = fpc_pkg::MK_SQ;
            if (step_ff == 3'd2) begin
               state_in = S_BW;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_BW: state_in = S_SQI;
         S_SQI: begin
            cnt_in  = '0;
            step_in = '0;
            if (sts.s_small) begin
               ctl.short_wr = 1'b1;
               if (plane_ff == LAST_PLANE) begin
                  state_in = S_DONE;
               end else begin
                  plane_in = plane_ff + 3'd1;
                  state_in = S_BA;
               end
            end else begin
               ctl.sqrt_init = 1'b1;
               state_in      = S_SQS;
            end
         end
         S_SQS: begin
            ctl.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DATA_WIDTH - 1)) begin
               state_in = S_DVI;
            end
         end
         S_DVI: begin
            ctl.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DVS;
         end
         S_DVS: begin
            ctl.div_step = 1'b1;
            cnt_in       = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW - 1)) begin
               state_in = S_DVW;
            end
         end
         // store one normal component or the offset
         S_DVW: begin
            ctl.div_wr = 1'b1;
            if (step_ff == 3'd3) begin
               step_in = '0;
               if (plane_ff == LAST_PLANE) begin
                  state_in = S_DONE;
               end else begin
                  plane_in = plane_ff + 3'd1;
                  state_in = S_BA;
               end
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = S_DVI;
            end
         end
         // test: pick the next active plane
         S_TP: begin
            step_in = '0;
            if (plane_ff == END_PLANE) begin
               state_in = S_DONE;
            end else if (!sts.plane_on) begin
               plane_in = plane_ff + 3'd1;
            end else begin
               ctl.acc_clr = 1'b1;
               state_in    = S_TM;
            end
         end
         // distance products, then box spread products
         S_TM: begin
            ctl.mul_en = 1'b1;
            if (step_ff < 3'd3) begin
               ctl.mul_kind = fpc_pkg::MK_DIST;
               ctl.step     = step_ff;
            end else begin
               ctl.mul_kind = fpc_pkg::MK_SPRD;
               ctl.step     = step_ff - 3'd3;
            end
            step_in = step_ff + 3'd1;
            if ((is_sph && step_ff == 3'd2) || step_ff == 3'd5) begin
               state_in = S_TW;
            end
         end
         S_TW: state_in = S_TE;
         S_TE: begin
            plane_in = plane_ff + 3'd1;
            state_in = S_TP;
            if (is_sph) begin
               if (sts.sph_cull) begin
                  ctl.res_cull = 1'b1;
                  state_in     = S_DONE;
               end
            end else if (sts.box_cull) begin
               ctl.res_cull = 1'b1;
               state_in     = S_DONE;
            end else if (sts.box_straddle) begin
               ctl.res_mark = 1'b1;
            end
         end
         S_DONE: begin
            if (!rv_ff || rsp_tready) begin
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rv_in = rv_ff;
      if (ctl.out_load) begin
         rv_in = 1'b1;
      end else if (rsp_tready) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         plane_ff <= '0;
         step_ff  <= '0;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         plane_ff <= plane_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

endmodule

### design/frustum_plane_cull.sv
// frustum_plane_cull: top level of the box and sphere frustum culling block
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser cmd, tdata group, centre/entries, extents, mask
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata visible, clip_mask
//
// one item is worked on at a time; the next is taken once the result sits in the
// output register, which holds it until rsp_tready.
// sphere test: every plane, each through the shared multiplier.
// box test: only the planes enabled in the mask, each through the shared multiplier.
// load: each plane is set by the bit-serial square root and the one-bit-a-cycle
// divider; a degenerate plane skips both.
// reset is synchronous and clears the matrix, the planes and the handshake state.
`timescale 1ns / 1ps
module frustum_plane_cull #(
   parameter int DATA_WIDTH = 32,
   localparam int REQ_TW = ((7 * DATA_WIDTH + 5 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // low to high: group_index, val_x, val_y, val_z, val_w, ext_x, ext_y, ext_z, in_mask
   input  logic [REQ_TW-1:0] req_tdata,
   // cmd
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // low to high: visible, clip_mask
   output logic [7:0]        rsp_tdata
);

   fpc_pkg::ctl_type ctl;
   fpc_pkg::sts_type sts;

   // sequencer
   fpc_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   // arithmetic and plane store
   fpc_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### test/tb_frustum_plane_cull.sv
// tb_frustum_plane_cull: stream testbench for the box and sphere frustum cull block
`timescale 1ns / 1ps
module tb_frustum_plane_cull;

   localparam int DW       = 32;
   localparam int REQ_TW   = ((7 * DW + 5 + 7) / 8) * 8;
   localparam int IDLE_MAX = 20000;
   localparam int N_RANDOM = 1200;

   typedef struct {
      logic [1:0]        cmd;
      logic [1:0]        grp;
      logic signed [31:0] vx, vy, vz, vw;
      logic [30:0]       ex, ey, ez;
      logic [5:0]        msk;
   } cull_item_type;

   typedef struct {
      logic       visible;
      logic [5:0] clip;
   } cull_res_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_TW-1:0] req_tdata = '0;
   logic [1:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;

   cull_item_type pending_items[$];
   cull_res_type  expected_res[$];
   cull_item_type in_flight;
   int         phase = 0;
   int         mismatches = 0;
   int         results_seen = 0;
   int         hold_left = 0;
   int         idle_cycles = 0;
   int         stim_done = 0;

   // predictor state
   longint mat[16];
   longint nrm[18];
   longint ofs[6];

   always #5 clock = ~clock;

   frustum_plane_cull #(.DATA_WIDTH(DW)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // rebuild the six normalized planes from the clip matrix
   task automatic rebuild_planes();
      longint a[3];
      longint d, len;
      longint unsigned s;
      int k;
      bit neg;
      for (int p = 0; p < fpc_pkg::PLANES; p++) begin
         k = p / 2;
         neg = (p == 0 || p == 3 || p == 4);
         s = 0;
         for (int i = 0; i < 3; i++) begin
            a[i] = sat32(neg ? mat[3+4*i] - mat[k+4*i] : mat[3+4*i] + mat[k+4*i]);
            s = s + longint'(a[i] * a[i]);
         end
         d = sat32(neg ? mat[15] - mat[12+k] : mat[15] + mat[12+k]);
         if (s > fpc_pkg::LEN_MIN_SQ) begin
            len = longint'(int_sqrt(s));
            for (int i = 0; i < 3; i++)
               nrm[p*3+i] = sat32((a[i] * (64'sd1 << fpc_pkg::NRM_FRAC)) / len);
            ofs[p] = sat32((d * (64'sd1 << fpc_pkg::OFF_FRAC)) / len);
         end else begin
            for (int i = 0; i < 3; i++)
               nrm[p*3+i] = sat32(a[i] * (64'sd1 << fpc_pkg::SHORT_SHIFT));
            ofs[p] = d;
         end
      end
   endtask

   function automatic longint plane_distance(int p, longint c[3]);
      longint acc;
      acc = ofs[p];
      for (int i = 0; i < 3; i++)
         acc += (nrm[p*3+i] * c[i]) / (64'sd1 << fpc_pkg::NRM_FRAC);
      return acc;
   endfunction

   // culling outcome of one item, updating the planes on a load
   task automatic predict_cull(input cull_item_type it, output cull_res_type r);
      longint c[3];
      longint e[3];
      longint pdist, spread, nv;
      r.visible = 1'b1;
      r.clip = '0;
      c[0] = it.vx; c[1] = it.vy; c[2] = it.vz;
      e[0] = it.ex; e[1] = it.ey; e[2] = it.ez;
      if (it.cmd == fpc_pkg::CMD_LOAD) begin
         mat[it.grp*4+0] = it.vx;
         mat[it.grp*4+1] = it.vy;
         mat[it.grp*4+2] = it.vz;
         mat[it.grp*4+3] = it.vw;
         rebuild_planes();
      end else if (it.cmd == fpc_pkg::CMD_BOX) begin
         for (int p = 0; p < fpc_pkg::PLANES; p++) begin
            if (it.msk[p]) begin
               pdist = plane_distance(p, c);
               spread = 0;
               for (int i = 0; i < 3; i++) begin
                  nv = nrm[p*3+i] < 0 ? -nrm[p*3+i] : nrm[p*3+i];
                  spread += (e[i] * nv) / (64'sd1 << fpc_pkg::NRM_FRAC);
               end
               if (pdist + spread < 0) begin
                  r.visible = 1'b0;
                  break;
               end
               if (pdist - spread < 0) r.clip[p] = 1'b1;
            end
         end
      end else if (it.cmd == fpc_pkg::CMD_SPHERE) begin
         for (int p = 0; p < fpc_pkg::PLANES; p++) begin
            if (plane_distance(p, c) <= -longint'(it.vw)) begin
               r.visible = 1'b0;
               break;
            end
         end
      end
   endtask

   function automatic logic signed [31:0] small_q(int span);
      return (int'($urandom_range(0, 2 * span)) - span) <<< 16 | int'($urandom_range(0, 65535));
   endfunction

   function automatic cull_item_type random_item();
      cull_item_type it;
      int sel;
      sel = $urandom_range(0, 99);
      it.cmd = sel < 8 ? fpc_pkg::CMD_LOAD :
               (sel < 55 ? fpc_pkg::CMD_BOX :
               (sel < 99 ? fpc_pkg::CMD_SPHERE : fpc_pkg::CMD_UNUSED));
      it.grp = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 8) begin
         it.vx = small_q(it.cmd == fpc_pkg::CMD_LOAD ? 2 : 20);
         it.vy = small_q(it.cmd == fpc_pkg::CMD_LOAD ? 2 : 20);
         it.vz = small_q(it.cmd == fpc_pkg::CMD_LOAD ? 2 : 20);
         it.vw = it.cmd == fpc_pkg::CMD_SPHERE ? small_q(4) : small_q(2);
         it.ex = 31'($urandom_range(0, 6 << 16));
         it.ey = 31'($urandom_range(0, 6 << 16));
         it.ez = 31'($urandom_range(0, 6 << 16));
      end else begin
         it.vx = $urandom; it.vy = $urandom; it.vz = $urandom; it.vw = $urandom;
         it.ex = 31'($urandom); it.ey = 31'($urandom); it.ez = 31'($urandom);
      end
      it.msk = 6'($urandom);
      return it;
   endfunction

   function automatic cull_item_type make_item(logic [1:0] cmd, logic [1:0] grp,
         int vx, int vy, int vz, int vw, logic [30:0] e, logic [5:0] msk);
      cull_item_type it;
      it.cmd = cmd; it.grp = grp;
      it.vx = vx; it.vy = vy; it.vz = vz; it.vw = vw;
      it.ex = e; it.ey = e; it.ez = e; it.msk = msk;
      return it;
   endfunction

   // driver: presents queued items, predicts each accepted one
   always @(posedge clock) begin
      cull_res_type r;
      int idle_pct;
      idle_pct = (phase == 1) ? 47 : (phase == 3 ? 36 : 0);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_cull(in_flight, r);
            expected_res.push_back(r);
         end
         if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            in_flight = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= in_flight.cmd;
            req_tdata <= REQ_TW'({in_flight.msk, in_flight.ez, in_flight.ey, in_flight.ex,
                                  in_flight.vw, in_flight.vz, in_flight.vy, in_flight.vx,
                                  in_flight.grp});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: random back-pressure, compares each result with the oldest expectation
   always @(posedge clock) begin
      cull_res_type want;
      int stall_pct;
      stall_pct = (phase == 2) ? 47 : (phase == 3 ? 36 : 0);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_res.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               want = expected_res.pop_front();
               if (rsp_tdata[0] !== want.visible || rsp_tdata[6:1] !== want.clip) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected visible %b clip %b, got visible %b clip %b",
                        results_seen, want.visible, want.clip, rsp_tdata[0], rsp_tdata[6:1]);
               end
            end
            if (results_seen == 300) hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(0, 99) >= stall_pct;
         end
      end
   end

   // watchdog on cycles without any accepted item or result
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_item(cull_item_type it);
      while (pending_items.size() >= 4) @(posedge clock);
      pending_items.push_back(it);
   endtask

   initial begin
      for (int i = 0; i < 16; i++) mat[i] = 0;
      for (int i = 0; i < 18; i++) nrm[i] = 0;
      for (int i = 0; i < 6; i++) ofs[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // degenerate planes straight after reset, radius zero and negative
      push_item(make_item(fpc_pkg::CMD_BOX, 0, 0, 0, 0, 0, 0, 6'h3f));
      push_item(make_item(fpc_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0));
      push_item(make_item(fpc_pkg::CMD_SPHERE, 0, 5 << 16, 0, 0, -(1 << 16), 0, 0));
      push_item(make_item(fpc_pkg::CMD_UNUSED, 3, -1, -1, -1, -1, 31'h7fffffff, 6'h3f));
      // identity-like clip matrix, then a degenerate plane through a tiny row
      push_item(make_item(fpc_pkg::CMD_LOAD, 0, 1 << 16, 0, 0, 0, 0, 0));
      push_item(make_item(fpc_pkg::CMD_LOAD, 1, 0, 1 << 16, 0, 0, 0, 0));
      push_item(make_item(fpc_pkg::CMD_LOAD, 2, 0, 0, 1 << 16, 1 << 16, 0, 0));
      push_item(make_item(fpc_pkg::CMD_LOAD, 3, 0, 0, 0, 1 << 16, 0, 0));
      push_item(make_item(fpc_pkg::CMD_BOX, 0, 0, 0, 0, 0, 1 << 15, 6'h3f));
      push_item(make_item(fpc_pkg::CMD_BOX, 0, 3 << 16, 0, 0, 0, 1 << 15, 6'h3f));
      push_item(make_item(fpc_pkg::CMD_BOX, 0, 1 << 16, 0, 0, 0, 1 << 15, 6'h3f));
      push_item(make_item(fpc_pkg::CMD_BOX, 0, 3 << 16, 0, 0, 0, 1 << 15, 6'h00));
      push_item(make_item(fpc_pkg::CMD_BOX, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0,
                          31'h7fffffff, 6'h3f));
      push_item(make_item(fpc_pkg::CMD_BOX, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0,
                          0, 6'h3f));
      push_item(make_item(fpc_pkg::CMD_SPHERE, 0, 0, 0, 0, 1 << 16, 0, 0));
      push_item(make_item(fpc_pkg::CMD_SPHERE, 0, 4 << 16, 0, 0, 1 << 16, 0, 0));
      push_item(make_item(fpc_pkg::CMD_SPHERE, 0, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0));
      push_item(make_item(fpc_pkg::CMD_SPHERE, 0, 0, 0, 0, 32'h80000000, 0, 0));
      push_item(make_item(fpc_pkg::CMD_LOAD, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                          32'h80000000, 0, 0));
      push_item(make_item(fpc_pkg::CMD_BOX, 0, 1 << 16, 1 << 16, 0, 0, 1 << 16, 6'h3f));
      push_item(make_item(fpc_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, 0));
      push_item(make_item(fpc_pkg::CMD_LOAD, 1, 1, 0, 0, 0, 0, 0));
      push_item(make_item(fpc_pkg::CMD_SPHERE, 0, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0));

      // random part, idling pattern changes every hundred items
      for (int i = 0; i < N_RANDOM; i++) begin
         phase = (i / 100) % 4;
         if (i == 600) begin
            // sender pause until the block has drained
            while (pending_items.size() != 0 || req_tvalid || expected_res.size() != 0)
               @(posedge clock);
         end
         push_item(random_item());
      end
      while (pending_items.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_res.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_res.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
